// ===== rtl/i2crts_pkg.sv =====
// Shared types and codes for the I2C register transfer sequencer.
// Used by i2crts_step and i2c_register_transfer_sequencer; no dependencies.
package i2crts_pkg;

    // Item opcodes
    localparam logic [2:0] OpBeginRead  = 3'd0;
    localparam logic [2:0] OpBeginWrite = 3'd1;
    localparam logic [2:0] OpStartDone  = 3'd2;
    localparam logic [2:0] OpAddrAcked  = 3'd3;
    localparam logic [2:0] OpTxEmpty    = 3'd4;
    localparam logic [2:0] OpRxFull     = 3'd5;

    // Sequencer phases
    localparam logic [2:0] PhIdle      = 3'd0;
    localparam logic [2:0] PhStart     = 3'd1;
    localparam logic [2:0] PhAddrW     = 3'd2;
    localparam logic [2:0] PhAddrAcked = 3'd3;
    localparam logic [2:0] PhRegSent   = 3'd4;
    localparam logic [2:0] PhRestart   = 3'd5;
    localparam logic [2:0] PhAddrR     = 3'd6;
    localparam logic [2:0] PhWriting   = 3'd7;

    // ACK and event interrupt action codes
    localparam logic [1:0] ActNone    = 2'd0;
    localparam logic [1:0] ActEnable  = 2'd1;
    localparam logic [1:0] ActDisable = 2'd2;

    // Event interrupt sources enabled on a begin
    localparam logic [2:0] IrqEnableBits = 3'h7;

    typedef struct packed {
        logic [2:0] opcode;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] phase;
        logic       is_read;
        logic [6:0] target_device;
        logic [7:0] target_register;
        logic [7:0] transfer_length;
        logic [7:0] byte_position;
    } seq_state_t;

    typedef struct packed {
        logic       drive_data_valid;
        logic [7:0] drive_data;
        logic       request_start;
        logic       request_stop;
        logic [1:0] ack_action;
        logic [1:0] event_irq_action;
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_byte;
        logic       byte_taken;
        logic       done_res;
        logic [2:0] phase_now;
    } result_t;

endpackage

// ===== rtl/i2c_register_transfer_sequencer.sv =====
// Top level of the I2C register transfer sequencer: input register, state and
// result register around i2crts_step. Depends on i2crts_pkg and i2crts_step.
//
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_ready     opcode, device_address,
//                                                  register_address, byte_count, data_byte
// result    out        result_valid / result_ready drive_data_valid .. phase_now
//
// One transaction per cycle sustained while result_ready is high; a transaction taken
// into the input register is loaded into the result register once that register is
// free, and its result is taken from there (input register, then result register).
// The sequencer state is updated as a transaction moves into the result register.
// Reset returns the sequencer to idle with all transfer fields cleared.
// A stalled result holds the input register; item_ready drops only when both
// registers are full and result_ready is low.
module i2c_register_transfer_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [2:0] opcode,
    input  logic [6:0] device_address,
    input  logic [7:0] register_address,
    input  logic [7:0] byte_count,
    input  logic [7:0] data_byte,
    output logic       result_valid,
    input  logic       result_ready,
    output logic       drive_data_valid,
    output logic [7:0] drive_data,
    output logic       request_start,
    output logic       request_stop,
    output logic [1:0] ack_action,
    output logic [1:0] event_irq_action,
    output logic       store_valid,
    output logic [7:0] store_index,
    output logic [7:0] store_byte,
    output logic       byte_taken,
    output logic       done_res,
    output logic [2:0] phase_now
);
    import i2crts_pkg::*;

    logic       in_full_reg;
    item_t      in_item_reg;
    logic       out_full_reg;
    result_t    out_res_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    res_next;
    logic       out_free;
    logic       advance;

    // Advance when the result register is empty or being drained
    assign out_free   = !out_full_reg || result_ready;
    assign advance    = in_full_reg && out_free;
    assign item_ready = !in_full_reg || advance;

    // Capture the incoming transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_full_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_item_reg <= '{opcode, device_address, register_address, byte_count, data_byte};
        end
    end

    i2crts_step u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    // Update sequencer state and load the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= '0;
            out_full_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg    <= state_next;
            out_full_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign result_valid     = out_full_reg;
    assign drive_data_valid = out_res_reg.drive_data_valid;
    assign drive_data       = out_res_reg.drive_data;
    assign request_start    = out_res_reg.request_start;
    assign request_stop     = out_res_reg.request_stop;
    assign ack_action       = out_res_reg.ack_action;
    assign event_irq_action = out_res_reg.event_irq_action;
    assign store_valid      = out_res_reg.store_valid;
    assign store_index      = out_res_reg.store_index;
    assign store_byte       = out_res_reg.store_byte;
    assign byte_taken       = out_res_reg.byte_taken;
    assign done_res         = out_res_reg.done_res;
    assign phase_now        = out_res_reg.phase_now;

    // A finished transaction always leaves the sequencer idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && done_res |-> phase_now == PhIdle)
        else $error("done without return to idle");

    // A taken write byte is always driven on the bus
    a_taken_drives: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && byte_taken |-> drive_data_valid)
        else $error("write byte taken but not driven");

    // Never drive and store in the same transaction
    a_drive_store_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(drive_data_valid && store_valid))
        else $error("drive and store in one transaction");

    // Result phase matches the committed sequencer state
    a_phase_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> phase_now == state_reg.phase)
        else $error("reported phase differs from state");

    // A stalled transaction holds the sequencer state
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a transaction");

endmodule

// ===== rtl/i2crts_step.sv =====
// Per-transaction decision logic: next sequencer state and bus actions.
// Purely combinational; depends on i2crts_pkg.
module i2crts_step (
    input  i2crts_pkg::seq_state_t state,
    input  i2crts_pkg::item_t      item,
    output i2crts_pkg::seq_state_t state_next,
    output i2crts_pkg::result_t    res
);
    import i2crts_pkg::*;

    logic [7:0] pos_inc;
    logic [8:0] pos_inc_plus;

    assign pos_inc      = state.byte_position + 8'd1;
    assign pos_inc_plus = {1'b0, pos_inc} + 9'd1;

    always_comb
    begin
        state_next = state;
        res        = '0;

        unique case (item.opcode) inside
            OpBeginRead, OpBeginWrite:
            begin
                // Replace any transfer in flight and ask for a start
                state_next.is_read         = (item.opcode == OpBeginRead);
                state_next.target_device   = item.device_address;
                state_next.target_register = item.register_address;
                state_next.transfer_length = item.byte_count;
                state_next.byte_position   = 8'd0;
                state_next.phase           = PhStart;
                res.request_start          = 1'b1;
                res.event_irq_action       = (IrqEnableBits != 3'd0) ? ActEnable : ActNone;
            end
            OpStartDone:
            begin
                // Drive the address byte with the direction bit
                if (state.phase != PhIdle)
                begin
                    res.drive_data_valid = 1'b1;
                    if (state.phase == PhRestart)
                    begin
                        res.drive_data   = {state.target_device, 1'b1};
                        state_next.phase = PhAddrR;
                    end
                    else
                    begin
                        res.drive_data   = {state.target_device, 1'b0};
                        state_next.phase = PhAddrW;
                    end
                end
            end
            OpAddrAcked:
            begin
                if (state.phase == PhAddrW)
                begin
                    state_next.phase = PhAddrAcked;
                end
                else if (state.phase == PhAddrR)
                begin
                    // Single-byte or zero-length read: NACK and stop right away
                    if (state.transfer_length > 8'd1)
                    begin
                        res.ack_action = ActEnable;
                    end
                    else
                    begin
                        res.ack_action   = ActDisable;
                        res.request_stop = 1'b1;
                    end
                end
            end
            OpTxEmpty:
            begin
                if (state.phase == PhAddrAcked)
                begin
                    res.drive_data_valid = 1'b1;
                    res.drive_data       = state.target_register;
                    state_next.phase     = PhRegSent;
                end
                else if (state.phase == PhRegSent)
                begin
                    if (state.is_read)
                    begin
                        res.request_start = 1'b1;
                        state_next.phase  = PhRestart;
                    end
                    else
                    begin
                        state_next.phase = PhWriting;
                    end
                end
                // Write data, entered in the same transaction as the register byte ends
                if (state_next.phase == PhWriting)
                begin
                    if (state.byte_position >= state.transfer_length)
                    begin
                        res.event_irq_action = ActDisable;
                        res.request_stop     = 1'b1;
                        res.done_res         = 1'b1;
                        state_next.phase     = PhIdle;
                        state_next.is_read   = 1'b0;
                    end
                    else
                    begin
                        res.drive_data_valid     = 1'b1;
                        res.drive_data           = item.data_byte;
                        res.byte_taken           = 1'b1;
                        state_next.byte_position = pos_inc;
                    end
                end
            end
            OpRxFull:
            begin
                if (state.phase == PhAddrR && state.is_read)
                begin
                    res.store_valid          = 1'b1;
                    res.store_index          = state.byte_position;
                    res.store_byte           = item.data_byte;
                    state_next.byte_position = pos_inc;
                    if (pos_inc >= state.transfer_length)
                    begin
                        res.request_stop = (state.transfer_length > 8'd1);
                        res.done_res     = 1'b1;
                        state_next.phase = PhIdle;
                    end
                    else if (pos_inc_plus == {1'b0, state.transfer_length})
                    begin
                        // NACK the byte that comes next, the last one
                        res.ack_action = ActDisable;
                    end
                end
            end
            default:
            begin
                // Unused opcodes are ignored
            end
        endcase

        res.phase_now = state_next.phase;
    end

endmodule

// ===== verif/i2crts_action_checker.sv =====
`timescale 1ns / 1ps
// Checker for the I2C register transfer sequencer: watches both channels,
// predicts each result and compares it. Depends on i2crts_pkg.
module i2crts_action_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic [2:0]  opcode,
    input  logic [6:0]  device_address,
    input  logic [7:0]  register_address,
    input  logic [7:0]  byte_count,
    input  logic [7:0]  data_byte,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic        drive_data_valid,
    input  logic [7:0]  drive_data,
    input  logic        request_start,
    input  logic        request_stop,
    input  logic [1:0]  ack_action,
    input  logic [1:0]  event_irq_action,
    input  logic        store_valid,
    input  logic [7:0]  store_index,
    input  logic [7:0]  store_byte,
    input  logic        byte_taken,
    input  logic        done_res,
    input  logic [2:0]  phase_now,
    output int unsigned fail_count,
    output int unsigned outstanding
);
    import i2crts_pkg::*;

    seq_state_t  transfer_state;
    result_t     expected_actions[$];
    result_t     observed;
    result_t     wanted;
    item_t       bus_item;
    int unsigned mismatches;

    // Advance the transfer state by one bus event and return the actions it calls for
    function automatic result_t sequence_bus_event(item_t ev);
        result_t act;
        act = '0;
        case (ev.opcode) inside
            OpBeginRead, OpBeginWrite:
            begin
                // A begin always replaces whatever transfer was running
                transfer_state.is_read         = (ev.opcode == OpBeginRead);
                transfer_state.target_device   = ev.device_address;
                transfer_state.target_register = ev.register_address;
                transfer_state.transfer_length = ev.byte_count;
                transfer_state.byte_position   = 8'd0;
                transfer_state.phase           = PhStart;
                act.request_start              = 1'b1;
                act.event_irq_action           = (IrqEnableBits != 0) ? ActEnable : ActNone;
            end
            OpStartDone:
            begin
                if (transfer_state.phase != PhIdle)
                begin
                    act.drive_data_valid = 1'b1;
                    if (transfer_state.phase == PhRestart)
                    begin
                        act.drive_data       = {transfer_state.target_device, 1'b1};
                        transfer_state.phase = PhAddrR;
                    end
                    else
                    begin
                        act.drive_data       = {transfer_state.target_device, 1'b0};
                        transfer_state.phase = PhAddrW;
                    end
                end
            end
            OpAddrAcked:
            begin
                if (transfer_state.phase == PhAddrW)
                begin
                    transfer_state.phase = PhAddrAcked;
                end
                else if (transfer_state.phase == PhAddrR)
                begin
                    // Single-byte (or zero-length) reads NACK and stop right away
                    if (transfer_state.transfer_length > 8'd1)
                    begin
                        act.ack_action = ActEnable;
                    end
                    else
                    begin
                        act.ack_action   = ActDisable;
                        act.request_stop = 1'b1;
                    end
                end
            end
            OpTxEmpty:
            begin
                if (transfer_state.phase == PhAddrAcked)
                begin
                    act.drive_data_valid = 1'b1;
                    act.drive_data       = transfer_state.target_register;
                    transfer_state.phase = PhRegSent;
                end
                else if (transfer_state.phase == PhRegSent)
                begin
                    if (transfer_state.is_read)
                    begin
                        act.request_start    = 1'b1;
                        transfer_state.phase = PhRestart;
                    end
                    else
                    begin
                        transfer_state.phase = PhWriting;
                    end
                end
                // Writing: push the next byte, or stop once all bytes are taken
                if (transfer_state.phase == PhWriting)
                begin
                    if (transfer_state.byte_position >= transfer_state.transfer_length)
                    begin
                        act.event_irq_action   = ActDisable;
                        act.request_stop       = 1'b1;
                        act.done_res           = 1'b1;
                        transfer_state.phase   = PhIdle;
                        transfer_state.is_read = 1'b0;
                    end
                    else
                    begin
                        act.drive_data_valid         = 1'b1;
                        act.drive_data               = ev.data_byte;
                        act.byte_taken               = 1'b1;
                        transfer_state.byte_position = transfer_state.byte_position + 8'd1;
                    end
                end
            end
            OpRxFull:
            begin
                if (transfer_state.phase == PhAddrR && transfer_state.is_read)
                begin
                    act.store_valid              = 1'b1;
                    act.store_index              = transfer_state.byte_position;
                    act.store_byte               = ev.data_byte;
                    transfer_state.byte_position = transfer_state.byte_position + 8'd1;
                    if (transfer_state.byte_position >= transfer_state.transfer_length)
                    begin
                        // Last byte in: stop only for multi-byte reads
                        if (transfer_state.transfer_length > 8'd1)
                        begin
                            act.request_stop = 1'b1;
                        end
                        act.done_res         = 1'b1;
                        transfer_state.phase = PhIdle;
                    end
                    else if ({1'b0, transfer_state.byte_position} + 9'd1
                             == {1'b0, transfer_state.transfer_length})
                    begin
                        // NACK the byte that comes next
                        act.ack_action = ActDisable;
                    end
                end
            end
            default:
            begin
            end
        endcase
        act.phase_now = transfer_state.phase;
        return act;
    endfunction

    // Report one field that differs from its prediction
    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Check each completed result transaction, then record the prediction for a new item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transfer_state = '0;
            expected_actions.delete();
            mismatches     = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                observed = {drive_data_valid, drive_data, request_start, request_stop,
                            ack_action, event_irq_action, store_valid, store_index,
                            store_byte, byte_taken, done_res, phase_now};
                if (expected_actions.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, observed);
                    mismatches++;
                end
                else
                begin
                    wanted = expected_actions.pop_front();
                    compare_field("drive_data_valid", wanted.drive_data_valid,
                                  observed.drive_data_valid);
                    compare_field("drive_data", wanted.drive_data, observed.drive_data);
                    compare_field("request_start", wanted.request_start,
                                  observed.request_start);
                    compare_field("request_stop", wanted.request_stop, observed.request_stop);
                    compare_field("ack_action", wanted.ack_action, observed.ack_action);
                    compare_field("event_irq_action", wanted.event_irq_action,
                                  observed.event_irq_action);
                    compare_field("store_valid", wanted.store_valid, observed.store_valid);
                    compare_field("store_index", wanted.store_index, observed.store_index);
                    compare_field("store_byte", wanted.store_byte, observed.store_byte);
                    compare_field("byte_taken", wanted.byte_taken, observed.byte_taken);
                    compare_field("done_res", wanted.done_res, observed.done_res);
                    compare_field("phase_now", wanted.phase_now, observed.phase_now);
                end
            end
            if (item_valid && item_ready)
            begin
                bus_item = {opcode, device_address, register_address, byte_count, data_byte};
                expected_actions.push_back(sequence_bus_event(bus_item));
            end
            fail_count  <= mismatches;
            outstanding <= expected_actions.size();
        end
    end

endmodule

// ===== verif/tb_i2c_register_transfer_sequencer.sv =====
`timescale 1ns / 1ps
// Testbench top for the I2C register transfer sequencer: drives bus event
// transactions and gives the verdict. Depends on i2crts_pkg and i2crts_action_checker.
module tb_i2c_register_transfer_sequencer;
    import i2crts_pkg::*;

    localparam int StallLimit = 2000;
    localparam int ItemTarget = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [2:0]  opcode = '0;
    logic [6:0]  device_address = '0;
    logic [7:0]  register_address = '0;
    logic [7:0]  byte_count = '0;
    logic [7:0]  data_byte = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic        drive_data_valid;
    logic [7:0]  drive_data;
    logic        request_start;
    logic        request_stop;
    logic [1:0]  ack_action;
    logic [1:0]  event_irq_action;
    logic        store_valid;
    logic [7:0]  store_index;
    logic [7:0]  store_byte;
    logic        byte_taken;
    logic        done_res;
    logic [2:0]  phase_now;
    int unsigned fail_count;
    int unsigned outstanding;

    logic        calm = 1'b0;
    int unsigned stalled_cycles = 0;
    int unsigned items_sent = 0;
    item_t       bus_script[$];

    i2c_register_transfer_sequencer dut (.*);
    i2crts_action_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Stall the result side at random, except during the calm stretch
    always @(posedge clk)
    begin
        result_ready <= rst_n && (calm || $urandom_range(99) >= 28);
    end

    // End the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
        begin
            stalled_cycles <= 0;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (stalled_cycles == StallLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Bus event with random don't-care fields
    function automatic item_t bus_event(logic [2:0] op, logic [7:0] dat);
        item_t ev;
        ev.opcode           = op;
        ev.device_address   = 7'($urandom_range(127));
        ev.register_address = 8'($urandom_range(255));
        ev.byte_count       = 8'($urandom_range(255));
        ev.data_byte        = dat;
        return ev;
    endfunction

    function automatic item_t noise_item();
        return bus_event(3'($urandom_range(7)), 8'($urandom_range(255)));
    endfunction

    // Queue the full event sequence of one read or write transfer
    task automatic queue_transfer(input bit rd, input logic [6:0] dev,
                                  input logic [7:0] reg_addr, input logic [7:0] cnt,
                                  input int data_pat);
        item_t ev;
        int    n;
        ev = bus_event(rd ? OpBeginRead : OpBeginWrite, 8'($urandom_range(255)));
        ev.device_address   = dev;
        ev.register_address = reg_addr;
        ev.byte_count       = cnt;
        bus_script.push_back(ev);
        bus_script.push_back(bus_event(OpStartDone, 8'($urandom_range(255))));
        bus_script.push_back(bus_event(OpAddrAcked, 8'($urandom_range(255))));
        bus_script.push_back(bus_event(OpTxEmpty, 8'($urandom_range(255))));
        if (rd)
        begin
            bus_script.push_back(bus_event(OpTxEmpty, 8'($urandom_range(255))));
            bus_script.push_back(bus_event(OpStartDone, 8'($urandom_range(255))));
            bus_script.push_back(bus_event(OpAddrAcked, 8'($urandom_range(255))));
            n = (cnt == 0) ? 1 : cnt;
            repeat (n)
            begin
                bus_script.push_back(bus_event(OpRxFull,
                    (data_pat < 0) ? 8'($urandom_range(255)) : 8'(data_pat)));
            end
        end
        else
        begin
            repeat (cnt)
            begin
                bus_script.push_back(bus_event(OpTxEmpty,
                    (data_pat < 0) ? 8'($urandom_range(255)) : 8'(data_pat)));
            end
            bus_script.push_back(bus_event(OpTxEmpty, 8'($urandom_range(255))));
        end
    endtask

    // Offer one transaction, idling at random first; return at the accepting edge
    task automatic send_item(input item_t ev);
        if (!calm)
        begin
            while ($urandom_range(99) < 28)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
        end
        item_valid       <= 1'b1;
        opcode           <= ev.opcode;
        device_address   <= ev.device_address;
        register_address <= ev.register_address;
        byte_count       <= ev.byte_count;
        data_byte        <= ev.data_byte;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
    endtask

    task automatic play_script();
        while (bus_script.size() > 0)
        begin
            send_item(bus_script.pop_front());
        end
    endtask

    // Hold the sender until every expected result is back
    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        int  pick;
        int  cut;
        logic [7:0] cnt;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Events while idle are ignored
        bus_script.push_back(bus_event(OpStartDone, 8'hFF));
        bus_script.push_back(bus_event(OpRxFull, 8'hFF));
        bus_script.push_back(bus_event(3'd7, 8'h00));
        // Zero-length write, zero-length read, then a read cut short by a one-byte write
        queue_transfer(1'b0, 7'h7F, 8'hFF, 8'd0, 0);
        queue_transfer(1'b1, 7'h00, 8'h00, 8'd0, 255);
        bus_script.push_back(bus_event(OpBeginRead, 8'h00));
        bus_script[bus_script.size() - 1].byte_count = 8'd2;
        queue_transfer(1'b0, 7'h55, 8'hAA, 8'd1, 0);
        play_script();
        drain_results();

        // Random transfers, some cut short or salted with stray events
        while (items_sent < ItemTarget)
        begin
            calm <= (items_sent >= 800 && items_sent < 1100);
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                pick = $urandom_range(199);
                cnt  = (pick < 2) ? 8'd255 : (pick < 16) ? 8'd0 : 8'($urandom_range(1, 6));
                queue_transfer(1'($urandom_range(1)), 7'($urandom_range(127)),
                               8'($urandom_range(255)), cnt, -1);
                if ($urandom_range(99) < 15)
                begin
                    cut = $urandom_range(1, bus_script.size() - 1);
                    while (bus_script.size() > cut)
                    begin
                        void'(bus_script.pop_back());
                    end
                end
                if ($urandom_range(99) < 20)
                begin
                    bus_script.insert($urandom_range(bus_script.size()), noise_item());
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    bus_script.push_back(noise_item());
                end
            end
            play_script();
            if ($urandom_range(99) < 2)
            begin
                drain_results();
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
